>>> src/gpbh_pkg.sv
// ----------------------------------------------------------------------------
// gpbh_pkg: shared definitions of the grid point binning histogram
// Store geometry, field widths, opcodes, register indexes and the store word.
// ----------------------------------------------------------------------------
package gpbh_pkg;

  localparam int GRID_CELLS      = 4096;
  localparam int CELL_BITS       = $clog2(GRID_CELLS);
  localparam int NODE_INDEX_BITS = 16;
  localparam int COUNT_BITS      = 16;
  localparam int COORD_BITS      = 16;
  localparam int DIM_BITS        = 13;
  localparam int PROD_BITS       = 2 * DIM_BITS;
  localparam int SUM_BITS        = PROD_BITS + 1;
  localparam int EPOCH_BITS      = 8;
  localparam int CFG_IDX_BITS    = 2;
  localparam int CFG_DATA_BITS   = 16;

  typedef logic [1:0] opcode_t;
  localparam opcode_t OP_INSERT = 2'd0;
  localparam opcode_t OP_QUERY  = 2'd1;
  localparam opcode_t OP_CLEAR  = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_X = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_Y = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH    = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT   = 2'd3;

  localparam logic [DIM_BITS-1:0] DIM_RESET = 13'd64;

  // One cell of the store: the count is live only when its epoch is current.
  typedef struct packed {
    logic [EPOCH_BITS-1:0]      epoch;
    logic [COUNT_BITS-1:0]      count;
    logic [NODE_INDEX_BITS-1:0] first;
  } cell_t;

  localparam int CELL_WORD_BITS = $bits(cell_t);

endpackage

>>> src/gpbh_ram.sv
// ----------------------------------------------------------------------------
// gpbh_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data (old data on a
// same-address collision).
// ----------------------------------------------------------------------------
module gpbh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/grid_point_binning_histogram.sv
// ----------------------------------------------------------------------------
// grid_point_binning_histogram: 2D uniform grid binning histogram
// Bins integer points into a 4096-cell store of saturating counts and
// first-node indexes; supports insert, query and a one-beat clear of all cells.
// ----------------------------------------------------------------------------
// Usage: one beat is accepted per cycle while in_ready is high, and every
// beat returns exactly one result beat, passing through the input register
// (address multiply), the stage-2 register (store read), the stage-3
// register (update) and the result register. Throughput is one beat per
// cycle while out_ready stays high and no scrub runs, set by the single
// read-modify-write of the cell store per beat; a beat that hits the same
// cell as the one just ahead takes the updated cell from a forwarding
// register. Clear bumps a store epoch instead of touching the cells. After
// reset, and after every 256th clear when the epoch wraps, a scrub pass
// rewrites all 4096 cells, one per cycle; in_ready stays low for the whole
// pass (plus draining of the clear ahead of it). Configuration writes are
// taken at any time but are meant to happen only while the block is idle.
// ----------------------------------------------------------------------------
module grid_point_binning_histogram (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration
  input  logic                                 cfg_we,
  input  logic [gpbh_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [gpbh_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  gpbh_pkg::opcode_t                    in_opcode,
  input  logic signed [gpbh_pkg::COORD_BITS-1:0] in_x,
  input  logic signed [gpbh_pkg::COORD_BITS-1:0] in_y,
  input  logic [gpbh_pkg::NODE_INDEX_BITS-1:0] in_node_index,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [gpbh_pkg::CELL_BITS-1:0]       out_cell_index,
  output logic [gpbh_pkg::COUNT_BITS-1:0]      out_count,
  output logic [gpbh_pkg::NODE_INDEX_BITS-1:0] out_first_node,
  output logic                                 out_out_of_range
);

  import gpbh_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [COORD_BITS-1:0] origin_x_r, origin_y_r;
  logic [DIM_BITS-1:0]          width_r, height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      width_r    <= DIM_RESET;
      height_r   <= DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ORIGIN_X: origin_x_r <= cfg_wdata[COORD_BITS-1:0];
        REG_ORIGIN_Y: origin_y_r <= cfg_wdata[COORD_BITS-1:0];
        REG_WIDTH:    width_r    <= cfg_wdata[DIM_BITS-1:0];
        REG_HEIGHT:   height_r   <= cfg_wdata[DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control
  // --------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, out_valid_r;
  logic sweep_r;
  logic [CELL_BITS-1:0]  sweep_cnt_r;
  logic [EPOCH_BITS-1:0] epoch_r;

  opcode_t op3_r;
  logic    wrap_clear;
  logic    o_free, s3_go, s3_free, s2_go, s2_free, s1_go, s1_free;

  // A clear at the last epoch starts the scrub; hold the beat behind it in
  // stage 2 so it does not read the store under the old epoch.
  assign wrap_clear = v3_r && (op3_r == OP_CLEAR) && (epoch_r == {EPOCH_BITS{1'b1}});

  assign o_free  = !out_valid_r || out_ready;
  assign s3_go   = v3_r && o_free;
  assign s3_free = !v3_r || s3_go;
  assign s2_go   = v2_r && s3_free && !sweep_r && !wrap_clear;
  assign s2_free = !v2_r || s2_go;
  assign s1_go   = v1_r && s2_free;
  assign s1_free = !v1_r || s1_go;
  assign in_ready = s1_free && !sweep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_free) v1_r <= in_valid && in_ready;
      if (s2_free) v2_r <= s1_go;
      if (s3_free) v3_r <= s2_go;
      if (o_free)  out_valid_r <= s3_go;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: input register, offsets, range checks and row multiply
  // --------------------------------------------------------------------------
  opcode_t                      op1_r;
  logic signed [COORD_BITS-1:0] x1_r, y1_r;
  logic [NODE_INDEX_BITS-1:0]   node1_r;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op1_r   <= in_opcode;
      x1_r    <= in_x;
      y1_r    <= in_y;
      node1_r <= in_node_index;
    end
  end

  logic signed [COORD_BITS:0] dx1, dy1;
  logic                       rng_ok1;
  logic [PROD_BITS-1:0]       prod1;

  assign dx1 = {x1_r[COORD_BITS-1], x1_r} - {origin_x_r[COORD_BITS-1], origin_x_r};
  assign dy1 = {y1_r[COORD_BITS-1], y1_r} - {origin_y_r[COORD_BITS-1], origin_y_r};
  // A negative offset has its sign bit set; otherwise compare as unsigned.
  assign rng_ok1 = !dx1[COORD_BITS] && !dy1[COORD_BITS]
                && (dx1[COORD_BITS-1:0] < {{(COORD_BITS-DIM_BITS){1'b0}}, width_r})
                && (dy1[COORD_BITS-1:0] < {{(COORD_BITS-DIM_BITS){1'b0}}, height_r});
  assign prod1 = width_r * dy1[DIM_BITS-1:0];

  // --------------------------------------------------------------------------
  // Stage 2: final address, store read
  // --------------------------------------------------------------------------
  opcode_t                    op2_r;
  logic [NODE_INDEX_BITS-1:0] node2_r;
  logic [DIM_BITS-1:0]        dx2_r;
  logic [PROD_BITS-1:0]       prod2_r;
  logic                       rng_ok2_r;

  always_ff @(posedge clk) begin
    if (s1_go) begin
      op2_r     <= op1_r;
      node2_r   <= node1_r;
      dx2_r     <= dx1[DIM_BITS-1:0];
      prod2_r   <= prod1;
      rng_ok2_r <= rng_ok1;
    end
  end

  logic [SUM_BITS-1:0] sum2;
  logic                in_grid2;

  assign sum2     = {{(SUM_BITS-DIM_BITS){1'b0}}, dx2_r} + {1'b0, prod2_r};
  assign in_grid2 = rng_ok2_r && (sum2 < SUM_BITS'(GRID_CELLS));

  // --------------------------------------------------------------------------
  // Stage 3: read-modify-write of the cell, result build
  // --------------------------------------------------------------------------
  logic [NODE_INDEX_BITS-1:0] node3_r;
  logic [CELL_BITS-1:0]       addr3_r;
  logic                       in_grid3_r;

  always_ff @(posedge clk) begin
    if (s2_go) begin
      op3_r      <= op2_r;
      node3_r    <= node2_r;
      addr3_r    <= sum2[CELL_BITS-1:0];
      in_grid3_r <= in_grid2;
    end
  end

  cell_t                 ram_rdata;
  cell_t                 fw_data_r;
  logic [CELL_BITS-1:0]  fw_addr_r;
  logic                  fw_valid_r;
  cell_t                 cell3;
  logic [COUNT_BITS-1:0] cnt_old3, cnt_new3, cnt_res3;
  logic [NODE_INDEX_BITS-1:0] first_new3;
  logic                  is_insert3, is_clear3, upd3;
  cell_t                 wr_word;
  logic                  ram_we;
  logic [CELL_BITS-1:0]  ram_waddr;
  cell_t                 ram_wdata;

  // Take the last written cell when the read raced with that write.
  assign cell3      = (fw_valid_r && (fw_addr_r == addr3_r)) ? fw_data_r : ram_rdata;
  assign cnt_old3   = (cell3.epoch == epoch_r) ? cell3.count : '0;
  assign is_insert3 = (op3_r == OP_INSERT);
  assign is_clear3  = (op3_r == OP_CLEAR);
  assign upd3       = s3_go && is_insert3 && in_grid3_r;
  assign cnt_new3   = (cnt_old3 == {COUNT_BITS{1'b1}}) ? cnt_old3
                                                       : cnt_old3 + COUNT_BITS'(1);
  // Record the node only on the first insert into an empty cell.
  assign first_new3 = (cnt_old3 == '0) ? node3_r : cell3.first;
  assign cnt_res3   = is_insert3 ? cnt_new3 : cnt_old3;

  assign wr_word.epoch = epoch_r;
  assign wr_word.count = cnt_new3;
  assign wr_word.first = first_new3;

  // Scrub has the write port to itself; stage 3 is empty while it runs.
  assign ram_we    = sweep_r || upd3;
  assign ram_waddr = sweep_r ? sweep_cnt_r : addr3_r;
  assign ram_wdata = sweep_r ? cell_t'('0) : wr_word;

  gpbh_ram #(
    .WIDTH (CELL_WORD_BITS),
    .DEPTH (GRID_CELLS)
  ) u_cell_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (s2_go),
    .raddr (sum2[CELL_BITS-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_valid_r <= 1'b0;
    end else if (sweep_r) begin
      fw_valid_r <= 1'b0;
    end else if (upd3) begin
      fw_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (upd3) begin
      fw_addr_r <= addr3_r;
      fw_data_r <= wr_word;
    end
  end

  // --------------------------------------------------------------------------
  // Epoch and scrub sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_r     <= '0;
      sweep_r     <= 1'b1;
      sweep_cnt_r <= '0;
    end else if (sweep_r) begin
      sweep_cnt_r <= sweep_cnt_r + CELL_BITS'(1);
      if (sweep_cnt_r == CELL_BITS'(GRID_CELLS - 1)) begin
        sweep_r <= 1'b0;
      end
    end else if (s3_go && is_clear3) begin
      // Advance the epoch; on wrap restart it and scrub every cell.
      epoch_r <= epoch_r + EPOCH_BITS'(1);
      if (wrap_clear) begin
        sweep_r     <= 1'b1;
        sweep_cnt_r <= '0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic [CELL_BITS-1:0]       out_cell_index_r;
  logic [COUNT_BITS-1:0]      out_count_r;
  logic [NODE_INDEX_BITS-1:0] out_first_node_r;
  logic                       out_out_of_range_r;

  always_ff @(posedge clk) begin
    if (s3_go) begin
      if (is_clear3 || !in_grid3_r) begin
        out_cell_index_r   <= '0;
        out_count_r        <= '0;
        out_first_node_r   <= '0;
        out_out_of_range_r <= !is_clear3;
      end else begin
        out_cell_index_r   <= addr3_r;
        out_count_r        <= cnt_res3;
        out_first_node_r   <= (cnt_res3 == '0) ? '0
                            : (is_insert3 ? first_new3 : cell3.first);
        out_out_of_range_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_cell_index   = out_cell_index_r;
  assign out_count        = out_count_r;
  assign out_first_node   = out_first_node_r;
  assign out_out_of_range = out_out_of_range_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // No pipeline read of the store while the scrub owns it.
  a_no_read_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    sweep_r |-> !s2_go)
    else $error("store read during scrub");

  // A clear leaving stage 3 advances the epoch or starts a scrub.
  a_clear_epoch: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_go && is_clear3 && !sweep_r) |=>
      (epoch_r == EPOCH_BITS'($past(epoch_r) + EPOCH_BITS'(1))) || sweep_r)
    else $error("clear did not advance epoch");

  // An out-of-range result carries an all-zero payload.
  a_oob_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_out_of_range_r) |->
      (out_cell_index_r == '0) && (out_count_r == '0) && (out_first_node_r == '0))
    else $error("out-of-range result with nonzero payload");

  // An empty cell never reports a first node.
  a_empty_first: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_count_r == '0)) |-> (out_first_node_r == '0))
    else $error("empty cell with first node");

endmodule

>>> verif/grid_bin_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_bin_checker: result checker for the grid point binning histogram
// Mirrors the configuration writes, bins every accepted input beat into its
// own copy of the cell store and compares each result beat, in order, with
// the bin outcome predicted for it.
// ----------------------------------------------------------------------------
module grid_bin_checker (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [gpbh_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [gpbh_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
  input  logic                                  in_valid,
  input  logic                                  in_ready,
  input  gpbh_pkg::opcode_t                     in_opcode,
  input  logic signed [gpbh_pkg::COORD_BITS-1:0] in_x,
  input  logic signed [gpbh_pkg::COORD_BITS-1:0] in_y,
  input  logic [gpbh_pkg::NODE_INDEX_BITS-1:0]  in_node_index,
  input  logic                                  out_valid,
  input  logic                                  out_ready,
  input  logic [gpbh_pkg::CELL_BITS-1:0]        out_cell_index,
  input  logic [gpbh_pkg::COUNT_BITS-1:0]       out_count,
  input  logic [gpbh_pkg::NODE_INDEX_BITS-1:0]  out_first_node,
  input  logic                                  out_out_of_range,
  output int                                    pending_bins,
  output int                                    mismatches
);

  import gpbh_pkg::*;

  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic [CELL_BITS-1:0]       cell_idx;
    logic [COUNT_BITS-1:0]      count;
    logic [NODE_INDEX_BITS-1:0] first;
    logic                       oor;
  } bin_result_t;

  // Own copy of the grid geometry and the cell store.
  int                         org_x;
  int                         org_y;
  logic [DIM_BITS-1:0]        span_w;
  logic [DIM_BITS-1:0]        span_h;
  logic [COUNT_BITS-1:0]      tally     [GRID_CELLS];
  logic [NODE_INDEX_BITS-1:0] first_idx [GRID_CELLS];

  bin_result_t bin_results_q[$];
  int          result_beats;
  int          bad_count;

  function automatic bin_result_t bin_point(opcode_t op, logic signed [COORD_BITS-1:0] px,
                                            logic signed [COORD_BITS-1:0] py,
                                            logic [NODE_INDEX_BITS-1:0] node);
    bin_result_t           r;
    int                    dx;
    int                    dy;
    longint                lin;
    logic [CELL_BITS-1:0]  addr;
    logic [COUNT_BITS-1:0] cnt;
    r = '0;
    if (op == OP_CLEAR) begin
      foreach (tally[i]) tally[i] = '0;
      return r;
    end
    dx = int'(px) - org_x;
    dy = int'(py) - org_y;
    if (dx < 0 || dy < 0 || dx >= int'(span_w) || dy >= int'(span_h)) begin
      r.oor = 1'b1;
      return r;
    end
    lin = longint'(dx) + longint'(span_w) * longint'(dy);
    if (lin >= GRID_CELLS) begin
      r.oor = 1'b1;
      return r;
    end
    addr = lin[CELL_BITS-1:0];
    cnt  = tally[addr];
    if (op == OP_INSERT) begin
      // first node goes in whenever the cell was empty, node 0 included
      if (cnt == '0) first_idx[addr] = node;
      if (cnt != '1) cnt = cnt + 1'b1;
      tally[addr] = cnt;
    end
    r.cell_idx = addr;
    r.count    = cnt;
    r.first    = (cnt != '0) ? first_idx[addr] : '0;
    return r;
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    bad_count++;
    if (bad_count <= MAX_REPORTS)
      $display("[%0t] result beat %0d: %s got %0d, want %0d",
               $realtime, result_beats, what, got, want);
  endtask

  always @(posedge clk) begin
    bin_result_t want;
    if (!rst_n) begin
      org_x  = 0;
      org_y  = 0;
      span_w = DIM_RESET;
      span_h = DIM_RESET;
      foreach (tally[i]) tally[i] = '0;
      foreach (first_idx[i]) first_idx[i] = '0;
      bin_results_q.delete();
      result_beats = 0;
      bad_count    = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ORIGIN_X: org_x  = int'($signed(cfg_wdata));
          REG_ORIGIN_Y: org_y  = int'($signed(cfg_wdata));
          REG_WIDTH:    span_w = cfg_wdata[DIM_BITS-1:0];
          REG_HEIGHT:   span_h = cfg_wdata[DIM_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        bin_results_q.push_back(bin_point(in_opcode, in_x, in_y, in_node_index));
      if (out_valid && out_ready) begin
        if (bin_results_q.size() == 0) begin
          flag_mismatch("unexpected beat, cell_index", out_cell_index, 0);
        end else begin
          want = bin_results_q.pop_front();
          if (out_cell_index !== want.cell_idx)
            flag_mismatch("cell_index", out_cell_index, want.cell_idx);
          if (out_count !== want.count)
            flag_mismatch("count", out_count, want.count);
          if (out_first_node !== want.first)
            flag_mismatch("first_node", out_first_node, want.first);
          if (out_out_of_range !== want.oor)
            flag_mismatch("out_of_range", out_out_of_range, want.oor);
        end
        result_beats++;
      end
    end
    pending_bins <= bin_results_q.size();
    mismatches   <= bad_count;
  end

endmodule

>>> verif/tb_grid_point_binning_histogram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_point_binning_histogram: testbench of the grid binning histogram
// Drives insert, query and clear beats over a range of grid geometries,
// with random gaps on the input and random stalls on the result channel,
// and leaves all checking to the grid bin checker beside the block.
// ----------------------------------------------------------------------------
module tb_grid_point_binning_histogram;
  import gpbh_pkg::*;

  localparam int      CYCLE_LIMIT  = 1_000_000;
  localparam int      HOLD_CYCLES  = 300;
  localparam int      SETTLE_TAIL  = 8;
  localparam opcode_t OP_SPARE     = 2'd3;   // unused code, acts as a query

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [CFG_IDX_BITS-1:0]       cfg_index;
  logic [CFG_DATA_BITS-1:0]      cfg_wdata;
  logic                          in_valid;
  logic                          in_ready;
  opcode_t                       in_opcode;
  logic signed [COORD_BITS-1:0]  in_x;
  logic signed [COORD_BITS-1:0]  in_y;
  logic [NODE_INDEX_BITS-1:0]    in_node_index;
  logic                          out_valid;
  logic                          out_ready;
  logic [CELL_BITS-1:0]          out_cell_index;
  logic [COUNT_BITS-1:0]         out_count;
  logic [NODE_INDEX_BITS-1:0]    out_first_node;
  logic                          out_out_of_range;

  int pending_bins;
  int mismatches;
  int cycle_count;

  // Geometry the stimulus aims at; the checker keeps its own copy.
  int grid_ox;
  int grid_oy;
  int grid_w;
  int grid_h;
  int last_x;
  int last_y;

  bit quiet;          // last part of the run: no gaps, no stalls
  bit sender_gaps;    // gaps on the input side in this phase
  bit hold_off_req;   // ask the receiver for one long stall

  grid_point_binning_histogram DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_x             (in_x),
    .in_y             (in_y),
    .in_node_index    (in_node_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_cell_index   (out_cell_index),
    .out_count        (out_count),
    .out_first_node   (out_first_node),
    .out_out_of_range (out_out_of_range)
  );

  grid_bin_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_x             (in_x),
    .in_y             (in_y),
    .in_node_index    (in_node_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_cell_index   (out_cell_index),
    .out_count        (out_count),
    .out_first_node   (out_first_node),
    .out_out_of_range (out_out_of_range),
    .pending_bins     (pending_bins),
    .mismatches       (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: random ready bursts, one long hold-off on request, and
  // steady ready once the run goes quiet.
  initial begin
    int left;
    int pick;
    left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        // hold ready low long enough for the pipe to fill and stall the input
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
        out_ready <= 1'b1;
        left = 0;
      end else if (quiet) begin
        out_ready <= 1'b1;
      end else if (left > 0) begin
        left--;
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
          out_ready <= 1'b0;
          left = $urandom_range(1, 8);
        end else if (pick < 9) begin
          out_ready <= 1'b1;
          left = $urandom_range(1, 8);
        end else begin
          // stretch with no stalls at all
          out_ready <= 1'b1;
          left = $urandom_range(30, 80);
        end
      end
    end
  end

  // Offer one beat and hold it until the block takes it.
  task automatic send_beat(opcode_t op, int px, int py, int node);
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_x          <= COORD_BITS'(px);
    in_y          <= COORD_BITS'(py);
    in_node_index <= NODE_INDEX_BITS'(node);
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid for the number of cycles given.
  task automatic hold_input(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Drop valid and wait until every predicted result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_bins != 0) @(posedge clk);
    repeat (SETTLE_TAIL) @(posedge clk);
  endtask

  // Write all four geometry registers, back to back, while the block is idle.
  task automatic set_grid(int ox, int oy, int w, int h);
    drain_results();
    grid_ox = ox;
    grid_oy = oy;
    grid_w  = w & 16'h1FFF;
    grid_h  = h & 16'h1FFF;
    cfg_we    <= 1'b1;
    cfg_index <= REG_ORIGIN_X;
    cfg_wdata <= CFG_DATA_BITS'(ox);
    @(posedge clk);
    cfg_index <= REG_ORIGIN_Y;
    cfg_wdata <= CFG_DATA_BITS'(oy);
    @(posedge clk);
    cfg_index <= REG_WIDTH;
    cfg_wdata <= CFG_DATA_BITS'(w);
    @(posedge clk);
    cfg_index <= REG_HEIGHT;
    cfg_wdata <= CFG_DATA_BITS'(h);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic int random_coord();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  // Random beats: mostly points inside the grid, often the same cell again,
  // the rest near the grid edge or anywhere in the coordinate space.
  task automatic run_random(int n_beats);
    int      pick;
    int      m;
    int      lim_w;
    int      lim_h;
    int      px;
    int      py;
    int      node;
    opcode_t op;
    for (int i = 0; i < n_beats; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 58)      op = OP_INSERT;
      else if (pick < 88) op = OP_QUERY;
      else if (pick < 92) op = OP_CLEAR;
      else if (pick < 96) op = OP_SPARE;
      else                op = OP_INSERT;
      m = $urandom_range(0, 99);
      if (m < 30) begin
        px = last_x;
        py = last_y;
      end else if (m < 85 && grid_w > 0 && grid_h > 0) begin
        lim_w = ($urandom_range(0, 1) != 0) ? grid_w : ((grid_w < 6) ? grid_w : 6);
        lim_h = ($urandom_range(0, 1) != 0) ? grid_h : ((grid_h < 6) ? grid_h : 6);
        px = grid_ox + int'($urandom_range(0, lim_w - 1));
        py = grid_oy + int'($urandom_range(0, lim_h - 1));
      end else if (m < 93) begin
        // just outside one of the grid borders
        px = grid_ox + (($urandom_range(0, 1) != 0) ? -1 : grid_w);
        py = grid_oy + int'($urandom_range(0, grid_h));
        if ($urandom_range(0, 1) != 0) begin
          px = grid_ox + int'($urandom_range(0, grid_w));
          py = grid_oy + (($urandom_range(0, 1) != 0) ? -1 : grid_h);
        end
      end else begin
        px = random_coord();
        py = random_coord();
      end
      // wrap to the 16-bit coordinate space the port carries
      px = int'(16'(px));
      py = int'(16'(py));
      if (px > 32767) px -= 65536;
      if (py > 32767) py -= 65536;
      last_x = px;
      last_y = py;
      case ($urandom_range(0, 9))
        0:       node = 0;
        1:       node = 16'hFFFF;
        default: node = $urandom_range(0, 65535);
      endcase
      if (!quiet && sender_gaps && $urandom_range(0, 5) == 0)
        hold_input($urandom_range(1, 8));
      send_beat(op, px, py, node);
    end
  endtask

  initial begin
    int w;
    int h;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_ORIGIN_X;
    cfg_wdata     <= '0;
    in_valid      <= 1'b0;
    in_opcode     <= OP_INSERT;
    in_x          <= '0;
    in_y          <= '0;
    in_node_index <= '0;
    cycle_count   <= 0;
    quiet        = 1'b0;
    sender_gaps  = 1'b1;
    hold_off_req = 1'b0;
    grid_ox = 0;
    grid_oy = 0;
    grid_w  = 64;
    grid_h  = 64;
    last_x  = 0;
    last_y  = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed beats on the reset geometry (origin 0, 64 by 64).
    send_beat(OP_QUERY,  0, 0, 0);              // empty cell reads as zero
    send_beat(OP_INSERT, 0, 0, 0);              // node 0 becomes first node
    send_beat(OP_INSERT, 0, 0, 16'hFFFF);       // first node stays 0
    send_beat(OP_QUERY,  0, 0, 16'hFFFF);
    send_beat(OP_INSERT, 63, 63, 16'hFFFF);     // top corner, last cell
    send_beat(OP_SPARE,  63, 63, 0);            // unused code reads the cell
    send_beat(OP_INSERT, -1, 0, 7);             // just left of the grid
    send_beat(OP_INSERT, 0, -1, 7);             // just below
    send_beat(OP_INSERT, 64, 0, 7);             // just right
    send_beat(OP_INSERT, 0, 64, 7);             // just above
    send_beat(OP_INSERT, 32767, 32767, 7);
    send_beat(OP_INSERT, -32768, -32768, 7);
    send_beat(OP_QUERY,  -32768, 32767, 0);
    send_beat(OP_CLEAR,  32767, -32768, 16'hFFFF);  // payload ignored
    send_beat(OP_QUERY,  0, 0, 0);
    send_beat(OP_QUERY,  63, 63, 0);
    send_beat(OP_INSERT, 0, 0, 16'h1234);       // refilled after clear
    send_beat(OP_INSERT, 5, 5, 16'h0001);       // same cell back to back
    send_beat(OP_INSERT, 5, 5, 16'h0002);
    send_beat(OP_INSERT, 5, 5, 16'h0003);
    send_beat(OP_QUERY,  5, 5, 0);
    send_beat(OP_CLEAR,  0, 0, 0);
    send_beat(OP_INSERT, 5, 5, 16'h0004);       // right behind a clear
    send_beat(OP_QUERY,  5, 5, 0);

    // Geometry extremes.
    set_grid(0, 0, 64, 64);
    run_random(150);
    set_grid(-32768, -32768, 4096, 1);
    run_random(150);
    set_grid(32767, 32767, 1, 4096);
    run_random(100);
    set_grid(0, 0, 4096, 4096);                 // most rows fall past the store
    run_random(150);
    set_grid(random_coord(), random_coord(), 0, 5);   // zero width
    run_random(50);
    set_grid(random_coord(), random_coord(), 5, 0);   // zero height
    run_random(50);
    set_grid(random_coord(), random_coord(), 8191, 8191);
    run_random(100);

    // Long receiver stall while the sender keeps offering beats.
    set_grid(-5, 3, 16, 16);
    sender_gaps  = 1'b0;
    hold_off_req = 1'b1;
    run_random(200);
    sender_gaps = 1'b1;

    // Small random grids.
    repeat (3) begin
      w = $urandom_range(1, 80);
      h = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 120 : 4096 / w);
      set_grid(random_coord(), random_coord(), w, h);
      run_random(80);
    end

    // Many clears, enough to wrap the store epoch at least once.
    set_grid(0, 0, 8, 8);
    repeat (260) begin
      send_beat(OP_CLEAR, random_coord(), random_coord(), $urandom_range(0, 65535));
      run_random(1);
    end

    // Quiet tail: random beats with no gaps and no stalls.
    set_grid(0, 0, 16, 16);
    quiet = 1'b1;
    send_beat(OP_QUERY, 2, 3, 0);
    run_random(50);

    drain_results();
    repeat (2 * SETTLE_TAIL) @(posedge clk);
    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
